>>> hdl/pasf_pkg.sv
package pasf_pkg;

  localparam int BUFFER_WORDS = 1024;
  localparam int REPEAT_COUNT = 1;
  localparam int SLOT_W       = $clog2(BUFFER_WORDS);
  localparam int REP_W        = (REPEAT_COUNT > 1) ? $clog2(REPEAT_COUNT) : 1;
  localparam int SLOT_OUT_W   = 10;
  localparam int SAMPLE_BITS  = 8;
  localparam int HIST_DEPTH   = 256;
  localparam int HIST_AW      = 8;
  localparam int QDEPTH       = 2;
  localparam int QPTR_W       = $clog2(QDEPTH);
  localparam int IN_TDATA_W   = 32;
  localparam int OUT_TDATA_W  = 72;
  localparam int OUT_PAD_W    = OUT_TDATA_W - 67;

  localparam logic [7:0] MONO8_OFFSET = 8'h40;
  localparam logic [8:0] LOWEST_NONE  = 9'd511;

  typedef enum logic [1:0] {
    ACT_STEREO = 2'd0,
    ACT_MONO16 = 2'd1,
    ACT_MONO8  = 2'd2,
    ACT_READ   = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    KIND_HOLD,
    KIND_STEREO,
    KIND_MONO,
    KIND_READ
  } kind_t;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_FIRST,
    BS_SECOND
  } bstate_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] word0;
    logic [7:0] word1;
    logic [7:0] bin;
    logic       block_end;
    logic [7:0] highest;
    logic [8:0] lowest;
  } cmd_t;

  function automatic logic [7:0] conv16(input logic [15:0] s);
    logic [15:0] u;
    u = s ^ 16'h8000;
    return u[15 -: SAMPLE_BITS];
  endfunction

endpackage

>>> hdl/pasf_front.sv
module pasf_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [pasf_pkg::IN_TDATA_W-1:0]  in_tdata,  // sample, byte_sample, bin_index
  input  logic [1:0]                       in_tuser,  // action
  input  logic                             in_tlast,  // block_end
  input  logic                             q_full,
  output logic                             q_push,
  output pasf_pkg::cmd_t                   q_cmd
);

  logic       rp_r, rp_nxt;
  logic [7:0] held_r, held_nxt;
  logic [7:0] hi_r, hi_nxt;
  logic [8:0] lo_r, lo_nxt;
  logic [7:0] v;
  logic [7:0] b;
  logic       accept;

  assign accept    = in_tvalid && !q_full;
  assign in_tready = !q_full;
  assign q_push    = accept;

  always_comb begin
    v        = pasf_pkg::conv16(in_tdata[15:0]);
    b        = in_tdata[23:16];
    rp_nxt   = rp_r;
    held_nxt = held_r;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    q_cmd.kind      = pasf_pkg::KIND_READ;
    q_cmd.word0     = '0;
    q_cmd.word1     = '0;
    q_cmd.bin       = in_tdata[31:24];
    q_cmd.block_end = in_tlast;
    case (pasf_pkg::act_t'(in_tuser))
      pasf_pkg::ACT_STEREO: begin
        if (v > hi_r) hi_nxt = v;
        if ({1'b0, v} < lo_r) lo_nxt = {1'b0, v};
        q_cmd.bin = v;
        if (rp_r) begin
          q_cmd.kind  = pasf_pkg::KIND_STEREO;
          q_cmd.word0 = held_r;
          q_cmd.word1 = v;
          rp_nxt      = 1'b0;
        end else begin
          q_cmd.kind = pasf_pkg::KIND_HOLD;
          held_nxt   = v;
          rp_nxt     = 1'b1;
        end
      end
      pasf_pkg::ACT_MONO16: begin
        q_cmd.kind  = pasf_pkg::KIND_MONO;
        q_cmd.word0 = v;
        q_cmd.word1 = v;
      end
      pasf_pkg::ACT_MONO8: begin
        q_cmd.kind  = pasf_pkg::KIND_MONO;
        q_cmd.word0 = {1'b0, b[7:1]} + pasf_pkg::MONO8_OFFSET;
        q_cmd.word1 = '0;
      end
      default: begin
        q_cmd.kind = pasf_pkg::KIND_READ;
      end
    endcase
    q_cmd.highest = hi_nxt;
    q_cmd.lowest  = lo_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r <= 1'b0;
      hi_r <= '0;
      lo_r <= pasf_pkg::LOWEST_NONE;
    end else if (accept) begin
      rp_r <= rp_nxt;
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) held_r <= held_nxt;
  end

endmodule

>>> hdl/pasf_queue.sv
module pasf_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pasf_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output pasf_pkg::cmd_t pop_cmd
);

  pasf_pkg::cmd_t               mem_r [pasf_pkg::QDEPTH];
  logic [pasf_pkg::QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [pasf_pkg::QPTR_W:0]    cnt_r;
  logic                         do_push, do_pop;

  assign full    = (cnt_r == (pasf_pkg::QPTR_W+1)'(pasf_pkg::QDEPTH));
  assign valid   = (cnt_r != '0);
  assign pop_cmd = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= (wr_ptr_r == pasf_pkg::QPTR_W'(pasf_pkg::QDEPTH - 1))
                               ? '0 : wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= (rd_ptr_r == pasf_pkg::QPTR_W'(pasf_pkg::QDEPTH - 1))
                               ? '0 : rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      cnt_r <= cnt_r + 1'b1;
      else if (!do_push && do_pop) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_cmd;
  end

endmodule

>>> hdl/pasf_back.sv
module pasf_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  input  pasf_pkg::cmd_t                    q_cmd,
  output logic                              q_pop,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [pasf_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic [2:0]                        out_tuser,
  output logic                              out_tlast
);

  pasf_pkg::bstate_t               state_r, state_nxt;
  pasf_pkg::cmd_t                  cur_r;
  logic [pasf_pkg::REP_W-1:0]      rep_r, rep_nxt;
  logic [pasf_pkg::SLOT_W-1:0]     ws_r, ws_nxt;
  logic [pasf_pkg::SLOT_W:0]       slot_inc;

  logic [31:0]                     hist_mem [pasf_pkg::HIST_DEPTH];
  logic [pasf_pkg::HIST_DEPTH-1:0] hist_vld_r;
  logic [31:0]                     rd_data_r;
  logic                            rd_vld_r;
  logic [31:0]                     count;
  logic                            hist_we;

  logic                              out_valid_r;
  logic [pasf_pkg::OUT_TDATA_W-1:0]  out_tdata_r, out_tdata_nxt;
  logic [2:0]                        out_tuser_r, out_tuser_nxt;
  logic                              out_tlast_r;

  logic                              out_free, emits, is_read, rep_last, adv;
  logic                              out_load, is_word, res_last;
  logic [7:0]                        word;
  logic                              half, wrap;
  logic [pasf_pkg::SLOT_OUT_W-1:0]   slot;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

  assign out_free = !out_valid_r || out_tready;
  assign emits    = (cur_r.kind == pasf_pkg::KIND_STEREO) || (cur_r.kind == pasf_pkg::KIND_MONO);
  assign is_read  = (cur_r.kind == pasf_pkg::KIND_READ);
  assign rep_last = (rep_r == pasf_pkg::REP_W'(pasf_pkg::REPEAT_COUNT - 1));
  assign count    = rd_vld_r ? rd_data_r : 32'd0;

  always_comb begin
    state_nxt = state_r;
    rep_nxt   = rep_r;
    q_pop     = 1'b0;
    out_load  = 1'b0;
    is_word   = 1'b0;
    res_last  = 1'b0;
    hist_we   = 1'b0;
    word      = '0;
    adv       = 1'b0;
    case (state_r)
      pasf_pkg::BS_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          rep_nxt   = '0;
          state_nxt = pasf_pkg::BS_FIRST;
        end
      end
      pasf_pkg::BS_FIRST: begin
        if (!emits || out_free) begin
          if (emits) begin
            out_load = 1'b1;
            is_word  = 1'b1;
            word     = cur_r.word0;
          end
          state_nxt = pasf_pkg::BS_SECOND;
        end
      end
      pasf_pkg::BS_SECOND: begin
        adv = !(emits || is_read) || out_free;
        if (adv) begin
          if (emits) begin
            out_load = 1'b1;
            is_word  = 1'b1;
            word     = cur_r.word1;
            res_last = rep_last;
          end
          if (is_read) begin
            out_load = 1'b1;
            res_last = 1'b1;
          end
          if ((cur_r.kind == pasf_pkg::KIND_HOLD || cur_r.kind == pasf_pkg::KIND_STEREO)
              && rep_r == '0) begin
            hist_we = 1'b1;
          end
          if (emits && !rep_last) begin
            rep_nxt   = rep_r + 1'b1;
            state_nxt = pasf_pkg::BS_FIRST;
          end else if (q_valid) begin
            q_pop     = 1'b1;
            rep_nxt   = '0;
            state_nxt = pasf_pkg::BS_FIRST;
          end else begin
            state_nxt = pasf_pkg::BS_IDLE;
          end
        end
      end
      default: begin
        state_nxt = pasf_pkg::BS_IDLE;
      end
    endcase
  end

  always_comb begin
    slot_inc = {1'b0, ws_r} + 1'b1;
    half     = 1'b0;
    wrap     = 1'b0;
    slot     = '0;
    ws_nxt   = ws_r;
    if (is_word) begin
      slot   = pasf_pkg::SLOT_OUT_W'(ws_r);
      half   = (slot_inc == (pasf_pkg::SLOT_W+1)'(pasf_pkg::BUFFER_WORDS / 2));
      wrap   = (slot_inc >= (pasf_pkg::SLOT_W+1)'(pasf_pkg::BUFFER_WORDS));
      ws_nxt = wrap ? '0 : slot_inc[pasf_pkg::SLOT_W-1:0];
    end
    out_tdata_nxt = {{pasf_pkg::OUT_PAD_W{1'b0}}, cur_r.lowest, cur_r.highest,
                     (is_word ? 32'd0 : count), word, slot};
    out_tuser_nxt = {res_last & cur_r.block_end, wrap, half};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pasf_pkg::BS_IDLE;
      rep_r       <= '0;
      ws_r        <= '0;
      out_valid_r <= 1'b0;
      hist_vld_r  <= '0;
    end else begin
      state_r <= state_nxt;
      rep_r   <= rep_nxt;
      ws_r    <= ws_nxt;
      if (out_load)        out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      if (hist_we) hist_vld_r[cur_r.bin] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_cmd;
    if (out_load) begin
      out_tdata_r <= out_tdata_nxt;
      out_tuser_r <= out_tuser_nxt;
      out_tlast_r <= res_last;
    end
  end

  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[cur_r.bin] <= count + 32'd1;
    rd_data_r <= hist_mem[cur_r.bin];
    rd_vld_r  <= hist_vld_r[cur_r.bin];
  end

endmodule

>>> hdl/pwm_audio_sample_formatter_unit.sv
// Path: an input transaction is written into the queue and popped into cur_r; its
// duty word is then registered in out_tdata_r, a histogram read result via rd_data_r first.
// Throughput: each item takes the back-end steps BS_FIRST (histogram read) and BS_SECOND
// (histogram write), and the two words go out one per step; output back-pressure can stall either step.
// Reset: rst_n synchronous, active low; clears stats, slot counter, queue
// and histogram valid bits at once, so no clearing pass is needed.
module pwm_audio_sample_formatter_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [pasf_pkg::IN_TDATA_W-1:0]   in_tdata,   // sample[15:0], byte_sample, bin_index
  input  logic [1:0]                        in_tuser,   // action
  input  logic                              in_tlast,   // block_end
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [pasf_pkg::OUT_TDATA_W-1:0]  out_tdata,  // slot, word, bin_count, highest, lowest
  output logic [2:0]                        out_tuser,  // half_mark, wrap_mark, block_done
  output logic                              out_tlast   // last
);

  logic           q_full, q_push, q_pop, q_valid;
  pasf_pkg::cmd_t push_cmd, pop_cmd;

  pasf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  pasf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_cmd  (pop_cmd)
  );

  pasf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_cmd      (pop_cmd),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
